// File: rtl/core/firewall_rule_first_match_assert.svh
// Assertion macros for the rule classifier.
// Define NO_ASSERTIONS to compile them away; no other dependencies.
`ifndef FIREWALL_RULE_FIRST_MATCH_ASSERT_SVH
`define FIREWALL_RULE_FIRST_MATCH_ASSERT_SVH
`ifndef NO_ASSERTIONS
`define FRFM_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("assertion failed");
`define FRFM_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("assertion failed");
`else
`define FRFM_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define FRFM_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// File: rtl/core/frfm_pkg.sv
// Shared constants, types and rule-match function for the rule classifier.
// No dependencies.
`default_nettype none
package frfm_pkg;
	localparam int RULE_SLOTS_DEF = 64;
	localparam logic [15:0] PORT_WILD = 16'd0;
	localparam logic [15:0] PORT_ABOVE = 16'd1023;
	localparam logic [7:0] PROTO_ICMP = 8'd1;
	localparam logic [7:0] PROTO_TCP = 8'd6;
	localparam logic [7:0] PROTO_UDP = 8'd17;
	localparam logic [7:0] PROTO_ANY = 8'd143;
	localparam logic [7:0] PROTO_OTHER = 8'd255;
	localparam logic [1:0] DIR_ANY = 2'd3;
	localparam logic [1:0] ACK_NO = 2'd1;
	localparam logic [1:0] ACK_YES = 2'd2;
	localparam logic [1:0] ACK_ANY = 2'd3;
	localparam logic [1:0] REASON_MATCH = 2'd0;
	localparam logic [1:0] REASON_NOMATCH = 2'd1;
	localparam logic [1:0] REASON_XMAS = 2'd2;

	typedef struct packed {
		logic [31:0] src;
		logic [31:0] dst;
		logic [5:0]  slen;
		logic [5:0]  dlen;
		logic [15:0] sp;
		logic [15:0] dp;
		logic [7:0]  proto;
		logic [1:0]  dir;
		logic [1:0]  ack;
		logic        acc;
	} rule_t;

	typedef struct packed {
		logic [31:0] src;
		logic [31:0] dst;
		logic [15:0] sp;
		logic [15:0] dp;
		logic [7:0]  proto;
		logic [1:0]  dir;
		logic        ack;
	} pkt_t;

	typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_DONE} state_t;

	function automatic logic [31:0] len_to_mask(input logic [5:0] len);
		logic [31:0] m;
		if (len == 6'd0) m = '0;
		else if (len >= 6'd32) m = '1;
		else m = 32'hFFFF_FFFF << (6'd32 - len);
		return m;
	endfunction

	function automatic logic port_hits(input logic [15:0] rp, input logic [15:0] pp);
		logic h;
		if (rp == PORT_WILD) h = 1'b1;
		else if (rp == PORT_ABOVE) h = (pp >= PORT_ABOVE);
		else h = (rp == pp);
		return h;
	endfunction

	function automatic logic rule_hits(input rule_t r, input pkt_t p);
		logic [31:0] sm;
		logic [31:0] dm;
		logic base;
		logic ackh;
		logic ports;
		sm = len_to_mask(r.slen);
		dm = len_to_mask(r.dlen);
		base = (r.dir == DIR_ANY || r.dir == p.dir)
			&& ((r.src & sm) == (p.src & sm))
			&& ((r.dst & dm) == (p.dst & dm))
			&& (r.proto == PROTO_ANY || r.proto == p.proto);
		ports = port_hits(r.sp, p.sp) && port_hits(r.dp, p.dp);
		if (r.ack == ACK_NO) ackh = !p.ack;
		else if (r.ack == ACK_YES) ackh = p.ack;
		else ackh = 1'b1;
		return base && ((p.proto == PROTO_ICMP)
			|| (p.proto == PROTO_TCP && ports && ackh)
			|| (p.proto == PROTO_UDP && ports));
	endfunction
endpackage
`default_nettype wire

// File: rtl/core/firewall_rule_first_match.sv
// Top level of the first-match rule classifier: control, write path and cell ring.
// Depends on frfm_pkg, frfm_cell and the assertion macro header.
`default_nettype none
`include "firewall_rule_first_match_assert.svh"
// Rules live in a ring of RULE_SLOTS cells that rotates one step per cycle
// while a beat is in its scan; a classify beat compares the packet against
// the rule at the ring head each cycle. The result strobe follows the full
// rotation, and a new beat can be taken in the idle cycle that follows the
// strobe. A rule write is also a full rotation, which replaces the chosen
// slot as it passes. Xmas TCP packets skip the rotation: their result
// strobe comes in the cycle right after the accepting edge. busy stays high
// up to and through the result strobe; the result sits on the ports for one
// cycle only and the receiver cannot stall it, so it must take every beat as
// it comes.
module firewall_rule_first_match
	import frfm_pkg::*;
#(
	parameter int RULE_SLOTS = RULE_SLOTS_DEF
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         start,
	output logic        busy,
	input  wire         cfg_we,
	input  wire  [6:0]  cfg_wdata,
	input  wire         action,
	input  wire  [5:0]  slot,
	input  wire  [31:0] source_address,
	input  wire  [31:0] dest_address,
	input  wire  [5:0]  source_prefix_len,
	input  wire  [5:0]  dest_prefix_len,
	input  wire  [15:0] source_port,
	input  wire  [15:0] dest_port,
	input  wire  [7:0]  protocol,
	input  wire  [1:0]  direction,
	input  wire  [3:0]  flag_bits,
	input  wire         rule_accepts,
	output logic        done,
	output logic        write_valid,
	output logic        accept,
	output logic [1:0]  reason_kind,
	output logic [5:0]  matched_slot
);
	localparam int CW = $clog2(RULE_SLOTS + 1);

	state_t state_q, state_nxt;
	logic [CW-1:0] idx_q;
	logic [6:0] count_q;
	logic [CW-1:0] limit;
	logic act_q, found_q, acc_q, wok_q, xmas_q;
	logic [5:0] slot_q, mslot_q;
	pkt_t pkt_q;
	rule_t wrule_q;
	rule_t ring [RULE_SLOTS];
	rule_t ring_in [RULE_SLOTS];
	logic shift;
	logic scan_end;
	logic in_ok;
	logic hit;

	assign limit = (32'(count_q) > 32'(RULE_SLOTS)) ? CW'(RULE_SLOTS) : CW'(count_q);
	assign shift = (state_q == ST_SCAN);
	assign scan_end = (idx_q == CW'(RULE_SLOTS - 1));
	assign hit = act_q && !found_q && (idx_q < limit) && rule_hits(ring[0], pkt_q);

	// Ring: cell k takes cell k+1, the last cell takes the head (or the new rule).
	genvar g;
	generate
		for (g = 0; g < RULE_SLOTS; g++) begin : g_cell
			if (g == RULE_SLOTS - 1) begin : g_last
				assign ring_in[g] = (!act_q && wok_q && CW'(slot_q) == idx_q)
					? wrule_q : ring[0];
			end else begin : g_mid
				assign ring_in[g] = ring[g+1];
			end
			frfm_cell u_cell (
				.clk(clk), .shift(shift), .rule_in(ring_in[g]), .rule_out(ring[g])
			);
		end
	endgenerate

	assign in_ok = (direction != 2'd0) && (source_prefix_len <= 6'd32)
		&& (dest_prefix_len <= 6'd32)
		&& (protocol == PROTO_ICMP || protocol == PROTO_TCP || protocol == PROTO_UDP
			|| protocol == PROTO_ANY || protocol == PROTO_OTHER)
		&& (flag_bits >= 4'd1) && (flag_bits <= 4'd3)
		&& (32'(slot) < 32'(RULE_SLOTS));

	always_comb begin
		state_nxt = state_q;
		case (state_q)
			ST_IDLE: if (start) state_nxt = (action && protocol == PROTO_TCP
				&& flag_bits[3:1] != 3'd0) ? ST_DONE : ST_SCAN;
			ST_SCAN: if (scan_end) state_nxt = ST_DONE;
			ST_DONE: state_nxt = ST_IDLE;
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_comb begin
		busy = (state_q != ST_IDLE);
		done = (state_q == ST_DONE);
		write_valid = done && !act_q && wok_q;
		accept = done && act_q && !xmas_q && found_q && acc_q;
		reason_kind = !(done && act_q) ? REASON_MATCH
			: xmas_q ? REASON_XMAS : found_q ? REASON_MATCH : REASON_NOMATCH;
		matched_slot = (done && act_q && !xmas_q && found_q) ? mslot_q : 6'd0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
			idx_q   <= '0;
			found_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cfg_we) count_q <= cfg_wdata;
			if (state_q == ST_IDLE) begin
				idx_q <= '0;
				found_q <= 1'b0;
			end else if (shift) begin
				idx_q <= idx_q + 1'b1;
				if (hit) found_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			act_q <= action;
			slot_q <= slot;
			wok_q <= in_ok;
			xmas_q <= action && protocol == PROTO_TCP && flag_bits[3:1] != 3'd0;
			pkt_q <= '{src: source_address, dst: dest_address, sp: source_port,
				dp: dest_port, proto: protocol, dir: direction, ack: flag_bits[0]};
			wrule_q <= '{src: source_address, dst: dest_address,
				slen: source_prefix_len, dlen: dest_prefix_len, sp: source_port,
				dp: dest_port, proto: protocol, dir: direction, ack: flag_bits[1:0],
				acc: rule_accepts};
		end
		if (hit) begin
			acc_q <= ring[0].acc;
			mslot_q <= 6'(idx_q);
		end
	end

	`FRFM_ASSERT_IMP(a_done_busy, clk, arst_n, done, busy)
	`FRFM_ASSERT_NEXT(a_done_idle, clk, arst_n, done, !busy)
	`FRFM_ASSERT_IMP(a_one_kind, clk, arst_n, write_valid, reason_kind == REASON_MATCH && !accept)
	`FRFM_ASSERT_IMP(a_xmas_drop, clk, arst_n, done && reason_kind == REASON_XMAS, !accept)
endmodule
`default_nettype wire

// File: rtl/core/frfm_cell.sv
// One rule-holding cell of the shift chain: stores a rule and hands it on.
// Depends on frfm_pkg.
`default_nettype none
module frfm_cell
	import frfm_pkg::*;
(
	input  wire   clk,
	input  wire   shift,
	input  rule_t rule_in,
	output rule_t rule_out
);
	rule_t rule_q;
	always_ff @(posedge clk) begin
		if (shift) begin
			rule_q <= rule_in;
		end
	end
	assign rule_out = rule_q;
endmodule
`default_nettype wire
